/* rtl/ujw_pkg.sv */
// ----------------------------------------------------------------------------
// ujw_pkg
// Types, lookup tables and set tests for the UTF-8 Japanese width normalizer.
// ----------------------------------------------------------------------------
package ujw_pkg;

  localparam logic [7:0] LEAD_E2 = 8'he2;
  localparam logic [7:0] LEAD_E3 = 8'he3;
  localparam logic [7:0] LEAD_EF = 8'hef;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  cnt;
    logic [31:0] data;
  } rom_t;

  function automatic logic [15:0] kana_rom(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0: v = 16'h83b2;  6'd1: v = 16'h82a1;  6'd2: v = 16'h82a3;  6'd3: v = 16'h82a5;
      6'd4: v = 16'h82a7;  6'd5: v = 16'h82a9;  6'd6: v = 16'h83a3;  6'd7: v = 16'h83a5;
      6'd8: v = 16'h83a7;  6'd9: v = 16'h8383;  6'd10: v = 16'h83bc; 6'd11: v = 16'h82a2;
      6'd12: v = 16'h82a4; 6'd13: v = 16'h82a6; 6'd14: v = 16'h82a8; 6'd15: v = 16'h82aa;
      6'd16: v = 16'h82ab; 6'd17: v = 16'h82ad; 6'd18: v = 16'h82af; 6'd19: v = 16'h82b1;
      6'd20: v = 16'h82b3; 6'd21: v = 16'h82b5; 6'd22: v = 16'h82b7; 6'd23: v = 16'h82b9;
      6'd24: v = 16'h82bb; 6'd25: v = 16'h82bd; 6'd26: v = 16'h82bf; 6'd27: v = 16'h8381;
      6'd28: v = 16'h8384; 6'd29: v = 16'h8386; 6'd30: v = 16'h8388; 6'd31: v = 16'h838a;
      6'd32: v = 16'h838b; 6'd33: v = 16'h838c; 6'd34: v = 16'h838d; 6'd35: v = 16'h838e;
      6'd36: v = 16'h838f; 6'd37: v = 16'h8392; 6'd38: v = 16'h8395; 6'd39: v = 16'h8398;
      6'd40: v = 16'h839b; 6'd41: v = 16'h839e; 6'd42: v = 16'h839f; 6'd43: v = 16'h83a0;
      6'd44: v = 16'h83a1; 6'd45: v = 16'h83a2; 6'd46: v = 16'h83a4; 6'd47: v = 16'h83a6;
      6'd48: v = 16'h83a8; 6'd49: v = 16'h83a9; 6'd50: v = 16'h83aa; 6'd51: v = 16'h83ab;
      6'd52: v = 16'h83ac; 6'd53: v = 16'h83ad; 6'd54: v = 16'h83af; 6'd55: v = 16'h83b3;
      6'd56: v = 16'h829b; 6'd57: v = 16'h829c;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic in_voiced(input logic [15:0] k);
    logic r;
    case (k)
      16'h818b, 16'h818d, 16'h818f, 16'h8191, 16'h8193, 16'h8195, 16'h8197, 16'h8199,
      16'h819b, 16'h819d, 16'h819f, 16'h81a1, 16'h81a4, 16'h81a6, 16'h81a8, 16'h81af,
      16'h81b2, 16'h81b5, 16'h81b8, 16'h81bb, 16'h82ab, 16'h82ad, 16'h82af, 16'h82b1,
      16'h82b3, 16'h82b5, 16'h82b7, 16'h82b9, 16'h82bb, 16'h82bd, 16'h8381, 16'h8384,
      16'h8386, 16'h8388, 16'h838f, 16'h8392, 16'h8395, 16'h8398, 16'h839b: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic in_semi(input logic [15:0] k);
    logic r;
    case (k)
      16'h81af, 16'h81b2, 16'h81b5, 16'h81b8, 16'h81bb,
      16'h838f, 16'h8392, 16'h8395, 16'h8398, 16'h839b: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic rom_t rom_lookup(input logic [7:0] hi, input logic [7:0] lo);
    rom_t        r;
    logic [15:0] v;
    logic [7:0]  idx;
    r = '0;
    v = '0;
    idx = '0;
    if (hi == 8'hbc && lo >= 8'h81 && lo <= 8'hbf && lo != 8'h82 && lo != 8'h87 &&
        lo != 8'hbc) begin
      r.hit = 1'b1; r.cnt = 3'd1; r.data = {24'h0, lo - 8'h60};
    end else if (hi == 8'hbd && lo >= 8'h81 && lo <= 8'h9d) begin
      r.hit = 1'b1; r.cnt = 3'd1; r.data = {24'h0, lo - 8'h20};
    end else if ((hi == 8'hbd && lo >= 8'ha6 && lo <= 8'hbf) ||
                 (hi == 8'hbe && lo >= 8'h80 && lo <= 8'h9f)) begin
      idx = (hi == 8'hbd) ? (lo - 8'ha6) : (lo - 8'h80 + 8'd26);
      v = kana_rom(idx[5:0]);
      r.hit = 1'b1; r.cnt = 3'd3; r.data = {8'h0, v[7:0], v[15:8], LEAD_E3};
    end else if (hi == 8'hbf && lo == 8'ha3) begin
      r.hit = 1'b1; r.cnt = 3'd1; r.data = 32'h7e;
    end else if (hi == 8'hbf && lo == 8'ha5) begin
      r.hit = 1'b1; r.cnt = 3'd1; r.data = 32'h5c;
    end
    return r;
  endfunction

endpackage

/* rtl/ujw_norm.sv */
// ----------------------------------------------------------------------------
// ujw_norm
// Per-item conversion, mark merge and release of the held character.
// ----------------------------------------------------------------------------
module ujw_norm import ujw_pkg::*; (
  input  logic [7:0]  b0,
  input  logic [7:0]  b1,
  input  logic [7:0]  b2,
  input  logic [7:0]  b3,
  input  logic [2:0]  cnt_raw,
  input  logic        eos,
  input  logic [31:0] held_char,
  input  logic [2:0]  held_count,
  output logic [1:0]  n_emit,
  output res_t        emit0,
  output res_t        emit1,
  output logic [31:0] held_char_nxt,
  output logic [2:0]  held_count_nxt
);

  logic [2:0]  c;
  logic [15:0] key;
  logic        daku, handaku, merged;
  logic [7:0]  h1, h2;
  logic [31:0] newch, cur_ch;
  logic [2:0]  ocnt, cur_cnt;
  logic        rel;
  rom_t        rom;

  always_comb begin
    c = (cnt_raw == 3'd0) ? 3'd1 : (cnt_raw > 3'd4) ? 3'd4 : cnt_raw;
    key = {held_char[15:8], held_char[23:16]};
    h1 = held_char[15:8];
    h2 = held_char[23:16];
    daku = (b0 == LEAD_EF && b1 == 8'hbe && b2 == 8'h9e) ||
           (b0 == LEAD_E3 && b1 == 8'h82 && b2 == 8'h9b);
    handaku = (b0 == LEAD_EF && b1 == 8'hbe && b2 == 8'h9f) ||
              (b0 == LEAD_E3 && b1 == 8'h82 && b2 == 8'h9c);
    merged = 1'b0;
    if (c == 3'd3 && held_count == 3'd3 && held_char[7:0] == LEAD_E3) begin
      if (daku) begin
        if (key == 16'h8186 || key == 16'h82a6) begin
          h1 = 8'h83; h2 = 8'hb4; merged = 1'b1;
        end else if (key == 16'h82bf) begin
          h1 = 8'h83; h2 = 8'h80; merged = 1'b1;
        end else if (in_voiced(key)) begin
          h2 = h2 + 8'd1; merged = 1'b1;
        end
      end else if (handaku && in_semi(key)) begin
        h2 = h2 + 8'd2; merged = 1'b1;
      end
    end

    rom = rom_lookup(b1, b2);
    newch = '0;
    ocnt = '0;
    if (c == 3'd3 && b0 == LEAD_E2 && b1 == 8'h80) begin
      case (b2)
        8'h98:   begin newch = 32'h60; ocnt = 3'd1; end
        8'h99:   begin newch = 32'h27; ocnt = 3'd1; end
        8'h9d:   begin newch = 32'h22; ocnt = 3'd1; end
        default: ocnt = 3'd0;
      endcase
    end else if (c == 3'd3 && b0 == LEAD_E3 && b1 == 8'h80 && b2 == 8'h80) begin
      newch = 32'h20; ocnt = 3'd1;
    end else if (c == 3'd3 && b0 == LEAD_EF && rom.hit) begin
      newch = rom.data; ocnt = rom.cnt;
    end
    if (ocnt == 3'd0) begin
      newch = {(c > 3'd3) ? b3 : 8'h0, (c > 3'd2) ? b2 : 8'h0,
               (c > 3'd1) ? b1 : 8'h0, b0};
      ocnt = c;
    end

    if (merged) begin
      cur_ch = {8'h0, h2, h1, LEAD_E3};
      cur_cnt = 3'd3;
    end else begin
      cur_ch = newch;
      cur_cnt = ocnt;
    end
    rel = !merged && held_count != 3'd0;

    emit0 = '{data: held_char, cnt: held_count, last: 1'b0};
    emit1 = '{data: cur_ch, cnt: cur_cnt, last: 1'b1};
    if (!rel) emit0 = emit1;
    n_emit = {1'b0, rel} + {1'b0, eos};

    held_char_nxt = eos ? 32'h0 : cur_ch;
    held_count_nxt = eos ? 3'd0 : cur_cnt;
  end

endmodule

/* rtl/utf8_japanese_width_normalizer.sv */
// ----------------------------------------------------------------------------
// utf8_japanese_width_normalizer
// Normalizes Japanese UTF-8 text one character per item, with mark merge.
// ----------------------------------------------------------------------------
// channel  ports                           direction
// in       in_byte0..3 in_count eos        valid/stall, one character
// out      out_byte0..3 out_count last     valid/stall, one character
//
// One item is accepted per cycle while in_stall is low; each item yields zero,
// one or two results into a four-entry result queue, drained at one result per
// cycle while out_stall is low. Input stalls while fewer than two queue entries
// are free. Reset clears the held character and empties the queue.
// ----------------------------------------------------------------------------
module utf8_japanese_width_normalizer import ujw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic [2:0] in_count,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] out_count,
  output logic       last_of_string
);

  logic [31:0] held_char_r, held_char_nxt;
  logic [2:0]  held_count_r, held_count_nxt;
  res_t        q_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  fill_r;
  logic [1:0]  n_emit;
  res_t        emit0, emit1, head;
  logic        push, pop;
  logic [1:0]  n_push;

  ujw_norm u_norm (
    .b0(in_byte0), .b1(in_byte1), .b2(in_byte2), .b3(in_byte3),
    .cnt_raw(in_count), .eos(end_of_string),
    .held_char(held_char_r), .held_count(held_count_r),
    .n_emit(n_emit), .emit0(emit0), .emit1(emit1),
    .held_char_nxt(held_char_nxt), .held_count_nxt(held_count_nxt)
  );

  assign in_stall = fill_r > 3'd2;
  assign push = in_valid && !in_stall;
  assign out_valid = fill_r != 3'd0;
  assign pop = out_valid && !out_stall;
  assign n_push = push ? n_emit : 2'd0;
  assign head = q_r[rp_r];
  assign out_byte0 = head.data[7:0];
  assign out_byte1 = head.data[15:8];
  assign out_byte2 = head.data[23:16];
  assign out_byte3 = head.data[31:24];
  assign out_count = head.cnt;
  assign last_of_string = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r <= '0;
      held_count_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        held_char_r <= held_char_nxt;
        held_count_r <= held_count_nxt;
      end
      if (n_push != 2'd0) q_r[wp_r] <= emit0;
      if (n_push == 2'd2) q_r[wp_r + 2'd1] <= emit1;
      wp_r <= wp_r + n_push;
      if (pop) rp_r <= rp_r + 2'd1;
      fill_r <= fill_r + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

/* test/utf8_japanese_width_normalizer_test.sv */
// ----------------------------------------------------------------------------
// utf8_japanese_width_normalizer_test
// Drives UTF-8 characters through the width normalizer with random bursts and
// output stalls, and checks every result against a behavioral predictor.
// ----------------------------------------------------------------------------
module utf8_japanese_width_normalizer_test;
  import ujw_pkg::*;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       eos;
  } char_item_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       last;
  } out_char_t;

  typedef struct packed {
    char_item_t item;
    logic       typed;
    out_char_t  want;
  } dir_row_t;

  localparam logic [7:0] MARK_B1 = 8'h82;
  localparam logic [7:0] WIDE_VOICED = 8'h9b;
  localparam logic [7:0] WIDE_SEMI = 8'h9c;
  localparam int DIR_ROWS = 25;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte0 = '0;
  logic [7:0] in_byte1 = '0;
  logic [7:0] in_byte2 = '0;
  logic [7:0] in_byte3 = '0;
  logic [2:0] in_count = 3'd1;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] out_count;
  logic       last_of_string;

  logic [31:0] held_char = '0;
  logic [2:0]  held_count = '0;
  out_char_t   expected_chars[$];
  int          fail_count = 0;
  logic        drain_done = 1'b0;
  dir_row_t    dir_rows[DIR_ROWS];

  utf8_japanese_width_normalizer uut (.*);

  always #4 clk = ~clk;

  function automatic logic [15:0] kana_of(input int idx);
    logic [15:0] t[58] = '{
      16'h83b2, 16'h82a1, 16'h82a3, 16'h82a5, 16'h82a7, 16'h82a9, 16'h83a3, 16'h83a5,
      16'h83a7, 16'h8383, 16'h83bc, 16'h82a2, 16'h82a4, 16'h82a6, 16'h82a8, 16'h82aa,
      16'h82ab, 16'h82ad, 16'h82af, 16'h82b1, 16'h82b3, 16'h82b5, 16'h82b7, 16'h82b9,
      16'h82bb, 16'h82bd, 16'h82bf, 16'h8381, 16'h8384, 16'h8386, 16'h8388, 16'h838a,
      16'h838b, 16'h838c, 16'h838d, 16'h838e, 16'h838f, 16'h8392, 16'h8395, 16'h8398,
      16'h839b, 16'h839e, 16'h839f, 16'h83a0, 16'h83a1, 16'h83a2, 16'h83a4, 16'h83a6,
      16'h83a8, 16'h83a9, 16'h83aa, 16'h83ab, 16'h83ac, 16'h83ad, 16'h83af, 16'h83b3,
      16'h829b, 16'h829c};
    return t[idx];
  endfunction

  function automatic bit voiced_base(input logic [15:0] k);
    logic [15:0] t[38] = '{
      16'h818b, 16'h818d, 16'h818f, 16'h8191, 16'h8193, 16'h8195, 16'h8197, 16'h8199,
      16'h819b, 16'h819d, 16'h819f, 16'h81a1, 16'h81a4, 16'h81a6, 16'h81a8, 16'h81af,
      16'h81b2, 16'h81b5, 16'h81b8, 16'h81bb, 16'h82ab, 16'h82ad, 16'h82af, 16'h82b1,
      16'h82b3, 16'h82b5, 16'h82b7, 16'h82b9, 16'h82bb, 16'h82bd, 16'h8381, 16'h8384,
      16'h8386, 16'h8388, 16'h838f, 16'h8392, 16'h8395, 16'h8398};
    foreach (t[i]) if (t[i] == k) return 1'b1;
    return k == 16'h839b;
  endfunction

  function automatic bit semi_base(input logic [15:0] k);
    logic [15:0] t[10] = '{16'h81af, 16'h81b2, 16'h81b5, 16'h81b8, 16'h81bb,
                           16'h838f, 16'h8392, 16'h8395, 16'h8398, 16'h839b};
    foreach (t[i]) if (t[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_char_t pack_char(input logic [31:0] ch, input logic [2:0] cnt,
                                          input logic last);
    out_char_t r;
    r.b0 = ch[7:0];
    r.b1 = (cnt > 1) ? ch[15:8] : 8'h00;
    r.b2 = (cnt > 2) ? ch[23:16] : 8'h00;
    r.b3 = (cnt > 3) ? ch[31:24] : 8'h00;
    r.cnt = cnt;
    r.last = last;
    return r;
  endfunction

  // Fold one character into the held state, queue what it releases.
  task automatic normalize_char(input char_item_t it);
    logic [2:0]  cnt;
    logic [7:0]  h1, h2, hi, lo;
    logic [15:0] key, v;
    logic [31:0] o;
    logic [2:0]  ocnt;
    out_char_t   p;
    bit          merged, daku, handaku;
    cnt = (it.cnt == 0) ? 3'd1 : (it.cnt > 4) ? 3'd4 : it.cnt;
    merged = 0;
    if (cnt == 3 && held_count == 3 && held_char[7:0] == LEAD_E3) begin
      h1 = held_char[15:8];
      h2 = held_char[23:16];
      key = {h1, h2};
      daku = (it.b0 == LEAD_EF && it.b1 == 8'hbe && it.b2 == 8'h9e) ||
             (it.b0 == LEAD_E3 && it.b1 == MARK_B1 && it.b2 == WIDE_VOICED);
      handaku = (it.b0 == LEAD_EF && it.b1 == 8'hbe && it.b2 == 8'h9f) ||
                (it.b0 == LEAD_E3 && it.b1 == MARK_B1 && it.b2 == WIDE_SEMI);
      if (daku) begin
        if (key == 16'h8186 || key == 16'h82a6) begin
          h1 = 8'h83; h2 = 8'hb4; merged = 1;
        end else if (key == 16'h82bf) begin
          h1 = 8'h83; h2 = 8'h80; merged = 1;
        end else if (voiced_base(key)) begin
          h2 = h2 + 8'd1; merged = 1;
        end
      end else if (handaku && semi_base(key)) begin
        h2 = h2 + 8'd2; merged = 1;
      end
      if (merged) held_char = {8'h00, h2, h1, LEAD_E3};
    end
    if (!merged) begin
      o = '0;
      ocnt = 0;
      hi = it.b1;
      lo = it.b2;
      if (cnt == 3 && it.b0 == LEAD_E2 && hi == 8'h80) begin
        if (lo == 8'h98) begin o = 32'h60; ocnt = 1; end
        else if (lo == 8'h99) begin o = 32'h27; ocnt = 1; end
        else if (lo == 8'h9d) begin o = 32'h22; ocnt = 1; end
      end else if (cnt == 3 && it.b0 == LEAD_E3 && hi == 8'h80 && lo == 8'h80) begin
        o = 32'h20; ocnt = 1;
      end else if (cnt == 3 && it.b0 == LEAD_EF) begin
        if (hi == 8'hbc && lo >= 8'h81 && lo <= 8'hbf && lo != 8'h82 && lo != 8'h87 &&
            lo != 8'hbc) begin
          o = {24'h0, 8'(lo - 8'h60)}; ocnt = 1;
        end else if (hi == 8'hbd && lo >= 8'h81 && lo <= 8'h9d) begin
          o = {24'h0, 8'(lo - 8'h20)}; ocnt = 1;
        end else if ((hi == 8'hbd && lo >= 8'ha6 && lo <= 8'hbf) ||
                     (hi == 8'hbe && lo >= 8'h80 && lo <= 8'h9f)) begin
          v = kana_of((hi == 8'hbd) ? lo - 8'ha6 : 26 + lo - 8'h80);
          o = {8'h00, v[7:0], v[15:8], LEAD_E3}; ocnt = 3;
        end else if (hi == 8'hbf && lo == 8'ha3) begin
          o = 32'h7e; ocnt = 1;
        end else if (hi == 8'hbf && lo == 8'ha5) begin
          o = 32'h5c; ocnt = 1;
        end
      end
      if (ocnt == 0) begin
        p = pack_char({it.b3, it.b2, it.b1, it.b0}, cnt, 0);
        o = {p.b3, p.b2, p.b1, p.b0};
        ocnt = cnt;
      end
      if (held_count != 0) expected_chars.push_back(pack_char(held_char, held_count, 0));
      held_char = o;
      held_count = ocnt;
    end
    if (it.eos) begin
      expected_chars.push_back(pack_char(held_char, held_count, 1));
      held_char = '0;
      held_count = '0;
    end
  endtask

  function automatic char_item_t mk(input logic [7:0] b0, b1, b2, input logic [2:0] cnt,
                                    input logic eos);
    return '{b0, b1, b2, 8'h00, cnt, eos};
  endfunction

  task automatic send_char(input char_item_t it);
    in_valid <= 1'b1;
    in_byte0 <= it.b0;
    in_byte1 <= it.b1;
    in_byte2 <= it.b2;
    in_byte3 <= it.b3;
    in_count <= it.cnt;
    end_of_string <= it.eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    normalize_char(it);
  endtask

  task automatic maybe_gap();
    int n;
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random character weighted toward merge pairs, conversions and string ends.
  function automatic char_item_t rand_char();
    char_item_t it;
    logic [15:0] k;
    int sel;
    it = {$urandom, 4'($urandom)};
    it.eos = ($urandom_range(0, 7) == 0);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        k = (sel == 0) ? kana_of($urandom_range(0, 57)) : 16'h8186;
        it.b0 = LEAD_E3; it.b1 = k[15:8]; it.b2 = k[7:0]; it.cnt = 3;
      end
      2: begin
        it.cnt = 3;
        if ($urandom_range(0, 1)) begin
          it.b0 = LEAD_EF; it.b1 = 8'hbe; it.b2 = 8'(8'h9e + $urandom_range(0, 1));
        end else begin
          it.b0 = LEAD_E3; it.b1 = MARK_B1;
          it.b2 = 8'(WIDE_VOICED + $urandom_range(0, 1));
        end
      end
      3, 4: begin
        it.b0 = LEAD_EF; it.b1 = 8'(8'hbc + $urandom_range(0, 3));
        it.b2 = 8'(8'h80 + $urandom_range(0, 63)); it.cnt = 3;
      end
      5: begin
        it.b0 = ($urandom_range(0, 1)) ? LEAD_E2 : LEAD_E3; it.b1 = 8'h80;
        it.b2 = 8'(8'h80 + $urandom_range(0, 31)); it.cnt = 3;
      end
      6: begin
        it.b0 = LEAD_E3; it.b1 = 8'(8'h81 + $urandom_range(0, 2));
        it.b2 = 8'(8'h80 + $urandom_range(0, 63)); it.cnt = 3;
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    dir_rows[0]  = '{mk(8'h41, 0, 0, 1, 1), 1, '{8'h41, 0, 0, 0, 1, 1}};
    dir_rows[1]  = '{mk(LEAD_E2, 8'h80, 8'h98, 3, 1), 1, '{8'h60, 0, 0, 0, 1, 1}};
    dir_rows[2]  = '{mk(LEAD_E2, 8'h80, 8'h99, 3, 1), 1, '{8'h27, 0, 0, 0, 1, 1}};
    dir_rows[3]  = '{mk(LEAD_E2, 8'h80, 8'h9d, 3, 1), 1, '{8'h22, 0, 0, 0, 1, 1}};
    dir_rows[4]  = '{mk(LEAD_E3, 8'h80, 8'h80, 3, 1), 1, '{8'h20, 0, 0, 0, 1, 1}};
    dir_rows[5]  = '{mk(LEAD_EF, 8'hbc, 8'h81, 3, 1), 1, '{8'h21, 0, 0, 0, 1, 1}};
    dir_rows[6]  = '{mk(LEAD_EF, 8'hbf, 8'ha3, 3, 1), 1, '{8'h7e, 0, 0, 0, 1, 1}};
    dir_rows[7]  = '{mk(LEAD_EF, 8'hbf, 8'ha5, 3, 1), 1, '{8'h5c, 0, 0, 0, 1, 1}};
    dir_rows[8]  = '{'{8'hff, 8'hff, 8'hff, 8'hff, 3'd7, 1'b1}, 1,
                     '{8'hff, 8'hff, 8'hff, 8'hff, 4, 1}};
    dir_rows[9]  = '{'{8'h00, 8'hff, 8'hff, 8'hff, 3'd0, 1'b1}, 1, '{0, 0, 0, 0, 1, 1}};
    dir_rows[10] = '{mk(LEAD_EF, 8'hbd, 8'ha6, 3, 0), 0, '0};
    dir_rows[11] = '{mk(LEAD_EF, 8'hbe, 8'h9f, 3, 0), 0, '0};
    dir_rows[12] = '{mk(LEAD_E3, 8'h81, 8'h86, 3, 0), 0, '0};
    dir_rows[13] = '{mk(LEAD_EF, 8'hbe, 8'h9e, 3, 0), 0, '0};
    dir_rows[14] = '{mk(LEAD_E3, 8'h82, 8'hbf, 3, 0), 0, '0};
    dir_rows[15] = '{mk(LEAD_E3, MARK_B1, WIDE_VOICED, 3, 0), 0, '0};
    dir_rows[16] = '{mk(LEAD_E3, 8'h82, 8'ha6, 3, 0), 0, '0};
    dir_rows[17] = '{mk(LEAD_E3, MARK_B1, WIDE_VOICED, 3, 0), 0, '0};
    dir_rows[18] = '{mk(LEAD_E3, 8'h83, 8'h8f, 3, 0), 0, '0};
    dir_rows[19] = '{mk(LEAD_E3, MARK_B1, WIDE_SEMI, 3, 0), 0, '0};
    dir_rows[20] = '{mk(LEAD_E3, 8'h81, 8'h8b, 3, 0), 0, '0};
    dir_rows[21] = '{mk(LEAD_EF, 8'hbe, 8'h9f, 3, 0), 0, '0};
    dir_rows[22] = '{mk(LEAD_E2, 8'h80, 8'h98, 2, 0), 0, '0};
    dir_rows[23] = '{'{LEAD_EF, 8'hbd, 8'h9d, 8'h00, 3'd3, 1'b0}, 0, '0};
    dir_rows[24] = '{mk(LEAD_E3, 8'h83, 8'h9b, 3, 1), 0, '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_char(dir_rows[i].item);
      if (dir_rows[i].typed && (expected_chars.size() == 0 ||
          expected_chars[$] != dir_rows[i].want)) begin
        $display("%0t table row %0d: expected %h, predicted %h", $time, i,
                 dir_rows[i].want, expected_chars.size() ? expected_chars[$] : '0);
        fail_count++;
      end
      maybe_gap();
    end
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    for (int i = 0; i < 550; i++) begin
      send_char(rand_char());
      maybe_gap();
    end
    send_char(mk(8'h2e, 0, 0, 1, 1));
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    drain_done <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 3) == 0) && ($time % 4000 < 3000);
  end

  always @(posedge clk) begin
    out_char_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte0, out_byte1, out_byte2, out_byte3, out_count, last_of_string};
      if (expected_chars.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (got != want) begin
          $display("%0t result mismatch: expected %h, actual %h", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (drain_done);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
